@@ src/jpeg_marker_segment_parser_unit_assert.svh @@
// assertion helpers for the marker segment parser
`ifndef JPEG_MARKER_SEGMENT_PARSER_UNIT_ASSERT_SVH
`define JPEG_MARKER_SEGMENT_PARSER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define JMSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jmsp assertion failed");

// next-cycle implication, checked out of reset
`define JMSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jmsp assertion failed");

`endif

@@ src/jmsp_pkg.sv @@
`default_nettype none

package jmsp_pkg;

  localparam logic [2:0] MAX_FILL_BYTES = 3'd6;

  localparam logic [7:0] BYTE_FILL = 8'hFF;
  localparam logic [7:0] MK_SOI    = 8'hD8;
  localparam logic [7:0] MK_EOI    = 8'hD9;
  localparam logic [7:0] MK_SOS    = 8'hDA;
  localparam logic [7:0] MK_APP1   = 8'hE1;

  typedef enum logic [6:0] {
    PH_SIG0 = 7'b0000001,
    PH_SIG1 = 7'b0000010,
    PH_MARK = 7'b0000100,
    PH_LENH = 7'b0001000,
    PH_LENL = 7'b0010000,
    PH_PAY  = 7'b0100000,
    PH_DONE = 7'b1000000
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_SIG     = 3'd0,
    ROLE_FILL    = 3'd1,
    ROLE_MARKER  = 3'd2,
    ROLE_LENH    = 3'd3,
    ROLE_LENL    = 3'd4,
    ROLE_PAYLOAD = 3'd5,
    ROLE_IGNORED = 3'd6
  } role_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_HEADER   = 3'd1,
    EV_SEG_END  = 3'd2,
    EV_SOS_DONE = 3'd3,
    EV_EOI_STOP = 3'd4,
    EV_NOT_JPEG = 3'd5,
    EV_BAD      = 3'd6
  } event_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  fill_count;
    logic [7:0]  marker;
    logic [15:0] length;
    logic [15:0] pay_count;
    logic        exif_match;
    logic        done;
  } state_t;

  localparam state_t RESET_STATE = '{
    phase:      PH_SIG0,
    fill_count: 3'd0,
    marker:     8'd0,
    length:     16'd0,
    pay_count:  16'd0,
    exif_match: 1'b0,
    done:       1'b0
  };

  typedef struct packed {
    role_t       role;
    logic [7:0]  marker;
    logic [15:0] length;
    logic [15:0] pay_index;
    logic        exif;
    event_t      evt;
    logic        finished;
  } result_t;

  // "Exif" signature, one byte per payload position
  function automatic logic [7:0] exif_sig(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = 8'h45;
      2'd1:    val = 8'h78;
      2'd2:    val = 8'h69;
      default: val = 8'h66;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

@@ src/jmsp_step.sv @@
`default_nettype none

module jmsp_step (
  input  wire jmsp_pkg::state_t  st,
  input  wire logic [7:0]        data_byte,
  input  wire logic              restart,
  output jmsp_pkg::state_t       st_nxt,
  output jmsp_pkg::result_t      res
);

  jmsp_pkg::state_t  cur;
  jmsp_pkg::state_t  nxt;
  jmsp_pkg::role_t   role;
  jmsp_pkg::event_t  evt;
  logic [15:0]       pidx;
  logic [15:0]       pay_inc;
  logic [15:0]       pay_len;
  logic [15:0]       len_full;

  always_comb begin
    cur      = restart ? jmsp_pkg::RESET_STATE : st;
    nxt      = cur;
    role     = jmsp_pkg::ROLE_IGNORED;
    evt      = jmsp_pkg::EV_NONE;
    pidx     = 16'd0;
    pay_inc  = cur.pay_count + 16'd1;
    pay_len  = cur.length - 16'd2;
    len_full = {cur.length[15:8], data_byte};

    unique case (cur.phase)
      jmsp_pkg::PH_SIG0: begin
        role = jmsp_pkg::ROLE_SIG;
        if (data_byte != jmsp_pkg::BYTE_FILL) begin
          evt = jmsp_pkg::EV_NOT_JPEG;
          nxt.phase = jmsp_pkg::PH_DONE;
          nxt.done = 1'b1;
        end else begin
          nxt.phase = jmsp_pkg::PH_SIG1;
        end
      end
      jmsp_pkg::PH_SIG1: begin
        role = jmsp_pkg::ROLE_SIG;
        if (data_byte != jmsp_pkg::MK_SOI) begin
          evt = jmsp_pkg::EV_NOT_JPEG;
          nxt.phase = jmsp_pkg::PH_DONE;
          nxt.done = 1'b1;
        end else begin
          nxt.phase = jmsp_pkg::PH_MARK;
          nxt.fill_count = 3'd0;
        end
      end
      jmsp_pkg::PH_MARK: begin
        if (data_byte == jmsp_pkg::BYTE_FILL) begin
          role = jmsp_pkg::ROLE_FILL;
          if (cur.fill_count >= jmsp_pkg::MAX_FILL_BYTES) begin
            evt = jmsp_pkg::EV_BAD;
            nxt.phase = jmsp_pkg::PH_DONE;
            nxt.done = 1'b1;
          end else begin
            nxt.fill_count = cur.fill_count + 3'd1;
          end
        end else begin
          role = jmsp_pkg::ROLE_MARKER;
          nxt.marker = data_byte;
          nxt.length = 16'd0;
          nxt.pay_count = 16'd0;
          nxt.exif_match = (data_byte == jmsp_pkg::MK_APP1);
          if (data_byte == jmsp_pkg::MK_EOI) begin
            evt = jmsp_pkg::EV_EOI_STOP;
            nxt.phase = jmsp_pkg::PH_DONE;
            nxt.done = 1'b1;
          end else begin
            nxt.phase = jmsp_pkg::PH_LENH;
          end
        end
      end
      jmsp_pkg::PH_LENH: begin
        role = jmsp_pkg::ROLE_LENH;
        nxt.length = {data_byte, 8'd0};
        nxt.phase = jmsp_pkg::PH_LENL;
      end
      jmsp_pkg::PH_LENL: begin
        role = jmsp_pkg::ROLE_LENL;
        nxt.length = len_full;
        if (len_full < 16'd2) begin
          evt = jmsp_pkg::EV_BAD;
          nxt.phase = jmsp_pkg::PH_DONE;
          nxt.done = 1'b1;
        end else if (len_full == 16'd2) begin
          // empty payload closes the segment right here
          if (cur.marker == jmsp_pkg::MK_SOS) begin
            evt = jmsp_pkg::EV_SOS_DONE;
            nxt.phase = jmsp_pkg::PH_DONE;
            nxt.done = 1'b1;
          end else begin
            evt = jmsp_pkg::EV_SEG_END;
            nxt.phase = jmsp_pkg::PH_MARK;
            nxt.fill_count = 3'd0;
          end
        end else begin
          evt = jmsp_pkg::EV_HEADER;
          nxt.phase = jmsp_pkg::PH_PAY;
        end
      end
      jmsp_pkg::PH_PAY: begin
        role = jmsp_pkg::ROLE_PAYLOAD;
        pidx = cur.pay_count;
        if (cur.exif_match && (cur.pay_count[15:2] == 14'd0) &&
            (data_byte != jmsp_pkg::exif_sig(cur.pay_count[1:0]))) begin
          nxt.exif_match = 1'b0;
        end
        nxt.pay_count = pay_inc;
        if (pay_inc >= pay_len) begin
          if (cur.marker == jmsp_pkg::MK_SOS) begin
            evt = jmsp_pkg::EV_SOS_DONE;
            nxt.phase = jmsp_pkg::PH_DONE;
            nxt.done = 1'b1;
          end else begin
            evt = jmsp_pkg::EV_SEG_END;
            nxt.phase = jmsp_pkg::PH_MARK;
            nxt.fill_count = 3'd0;
          end
        end
      end
      default: begin
        role = jmsp_pkg::ROLE_IGNORED;
        nxt.phase = jmsp_pkg::PH_DONE;
        nxt.done = 1'b1;
      end
    endcase

    st_nxt        = nxt;
    res.role      = role;
    res.marker    = nxt.marker;
    res.length    = nxt.length;
    res.pay_index = pidx;
    res.exif      = nxt.exif_match && (nxt.pay_count >= 16'd4);
    res.evt       = evt;
    res.finished  = nxt.done;
  end

endmodule

`default_nettype wire

@@ src/jpeg_marker_segment_parser_unit.sv @@
// channel  direction  handshake            payload
// in       input      in_valid/in_stall    in_data_byte, in_restart
// out      output     out_valid/out_stall  role, marker, length, index, exif, event, finished
//
// one word per cycle while in_stall is low: the parse state and the output
// register both load at the accepting edge, so the result can be taken at the next edge
// rst_n (synchronous) clears the parse state and the output valid
// in_stall follows out_stall only while a result is held in the output register
// in_restart clears the parse state before its own word is taken
`default_nettype none

module jpeg_marker_segment_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_restart,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_byte_role,
  output logic [7:0]       out_marker_code,
  output logic [15:0]      out_segment_length,
  output logic [15:0]      out_payload_index,
  output logic             out_exif_flag,
  output logic [2:0]       out_event_code,
  output logic             out_finished
);

  jmsp_pkg::state_t  state_r;
  jmsp_pkg::state_t  state_nxt;
  jmsp_pkg::result_t res_nxt;
  jmsp_pkg::result_t res_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              in_acc;
  logic              out_acc;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;

  jmsp_step u_step (
    .st        (state_r),
    .data_byte (in_data_byte),
    .restart   (in_restart),
    .st_nxt    (state_nxt),
    .res       (res_nxt)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_acc) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= jmsp_pkg::RESET_STATE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte_role      = res_r.role;
  assign out_marker_code    = res_r.marker;
  assign out_segment_length = res_r.length;
  assign out_payload_index  = res_r.pay_index;
  assign out_exif_flag      = res_r.exif;
  assign out_event_code     = res_r.evt;
  assign out_finished       = res_r.finished;

`include "jpeg_marker_segment_parser_unit_assert.svh"

  // a held result must hold back the input side
  `JMSP_ASSERT_NOW(a_hold_backpressure, out_valid_r && out_stall, in_stall)
  // every accepted word leaves a result in the output register
  `JMSP_ASSERT_NEXT(a_accept_gives_result, in_acc, out_valid_r)
  // once stopped, only a restart leaves the done state
  `JMSP_ASSERT_NEXT(a_done_sticks, state_r.done && !(in_acc && in_restart), state_r.done)
  // words after the stop are reported as ignored
  `JMSP_ASSERT_NEXT(a_done_ignored, state_r.done && in_acc && !in_restart,
                    res_r.role == jmsp_pkg::ROLE_IGNORED && res_r.finished)

endmodule

`default_nettype wire

@@ tb/tb_jpeg_marker_segment_parser_unit.sv @@
`timescale 1ns / 1ps

import jmsp_pkg::*;

localparam logic [31:0] EXIF_TAG = 32'h4578_6966;

class parse_scoreboard;
  phase_t      phase;
  logic [2:0]  fills;
  logic [7:0]  marker;
  logic [15:0] seg_len;
  logic [15:0] pay_cnt;
  logic        exif_ok;
  logic        stopped;
  result_t     expected_q[$];
  int          fails;

  function new();
    fails = 0;
    clear_state();
  endfunction

  function void clear_state();
    phase   = PH_SIG0;
    fills   = '0;
    marker  = '0;
    seg_len = '0;
    pay_cnt = '0;
    exif_ok = 1'b0;
    stopped = 1'b0;
  endfunction

  function void halt();
    phase   = PH_DONE;
    stopped = 1'b1;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // works out the result of one accepted word and queues it
  function role_t note_word(logic [7:0] b, logic rs);
    result_t r;
    role_t   role;
    event_t  ev;
    logic [15:0] idx;
    int      k;
    role = ROLE_IGNORED;
    ev   = EV_NONE;
    idx  = '0;
    if (rs) clear_state();
    case (phase)
      PH_SIG0: begin
        role = ROLE_SIG;
        if (b != BYTE_FILL) begin
          ev = EV_NOT_JPEG;
          halt();
        end else phase = PH_SIG1;
      end
      PH_SIG1: begin
        role = ROLE_SIG;
        if (b != MK_SOI) begin
          ev = EV_NOT_JPEG;
          halt();
        end else begin
          phase = PH_MARK;
          fills = '0;
        end
      end
      PH_MARK: begin
        if (b == BYTE_FILL) begin
          role = ROLE_FILL;
          if (fills >= MAX_FILL_BYTES) begin
            ev = EV_BAD;
            halt();
          end else fills = fills + 3'd1;
        end else begin
          role    = ROLE_MARKER;
          marker  = b;
          seg_len = '0;
          pay_cnt = '0;
          exif_ok = (b == MK_APP1);
          if (b == MK_EOI) begin
            ev = EV_EOI_STOP;
            halt();
          end else phase = PH_LENH;
        end
      end
      PH_LENH: begin
        role    = ROLE_LENH;
        seg_len = {b, 8'h00};
        phase   = PH_LENL;
      end
      PH_LENL: begin
        role         = ROLE_LENL;
        seg_len[7:0] = b;
        if (seg_len < 16'd2) begin
          ev = EV_BAD;
          halt();
        end else if (seg_len == 16'd2) begin
          if (marker == MK_SOS) begin
            ev = EV_SOS_DONE;
            halt();
          end else begin
            ev    = EV_SEG_END;
            phase = PH_MARK;
            fills = '0;
          end
        end else begin
          ev    = EV_HEADER;
          phase = PH_PAY;
        end
      end
      PH_PAY: begin
        role = ROLE_PAYLOAD;
        idx  = pay_cnt;
        k    = int'(pay_cnt[1:0]);
        if (exif_ok && pay_cnt < 16'd4 && b != EXIF_TAG[8*(3-k) +: 8]) exif_ok = 1'b0;
        pay_cnt = pay_cnt + 16'd1;
        if (pay_cnt >= seg_len - 16'd2) begin
          if (marker == MK_SOS) begin
            ev = EV_SOS_DONE;
            halt();
          end else begin
            ev    = EV_SEG_END;
            phase = PH_MARK;
            fills = '0;
          end
        end
      end
      default: begin
        role = ROLE_IGNORED;
        halt();
      end
    endcase
    r.role      = role;
    r.marker    = marker;
    r.length    = seg_len;
    r.pay_index = idx;
    r.exif      = exif_ok && (pay_cnt >= 16'd4);
    r.evt       = ev;
    r.finished  = stopped;
    expected_q.push_back(r);
    return role;
  endfunction

  function void cmp(string fld, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      fails++;
      if (fails <= 40)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, want, got);
    end
  endfunction

  function void check_word(result_t got);
    result_t want;
    if (expected_q.size() == 0) begin
      fails++;
      if (fails <= 40)
        $display("%0t: unexpected result word, expected none, actual role %0d event %0d",
                 $time, got.role, got.evt);
      return;
    end
    want = expected_q.pop_front();
    cmp("byte_role", 16'(want.role), 16'(got.role));
    cmp("marker_code", 16'(want.marker), 16'(got.marker));
    cmp("segment_length", want.length, got.length);
    cmp("payload_index", want.pay_index, got.pay_index);
    cmp("exif_flag", 16'(want.exif), 16'(got.exif));
    cmp("event_code", 16'(want.evt), 16'(got.evt));
    cmp("finished", 16'(want.finished), 16'(got.finished));
  endfunction
endclass

module tb_jpeg_marker_segment_parser_unit;

  localparam int LIVE_WORDS   = 650;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam int EXIF_NONE    = 0;
  localparam int EXIF_EXACT   = 1;
  localparam int EXIF_FLIPPED = 2;
  localparam logic [7:0] MK_SOF0 = 8'hC0;

  logic        clk;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_restart   = 1'b0;
  logic        out_stall    = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [2:0]  out_byte_role;
  logic [7:0]  out_marker_code;
  logic [15:0] out_segment_length;
  logic [15:0] out_payload_index;
  logic        out_exif_flag;
  logic [2:0]  out_event_code;
  logic        out_finished;

  parse_scoreboard sb;
  logic [7:0] stream_q[$];
  int in_idle_pct = 0;
  int stall_pct   = 0;
  int hold_left   = 0;
  int live_words  = 0;
  int cycles      = 0;

  jpeg_marker_segment_parser_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_restart         (in_restart),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte_role      (out_byte_role),
    .out_marker_code    (out_marker_code),
    .out_segment_length (out_segment_length),
    .out_payload_index  (out_payload_index),
    .out_exif_flag      (out_exif_flag),
    .out_event_code     (out_event_code),
    .out_finished       (out_finished)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("jpeg_marker_segment_parser_unit test failed");
        $finish;
      end
    end
  end

  // result side: check accepted words, stall at random or for a long hold
  initial begin
    result_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.role      = role_t'(out_byte_role);
        got.marker    = out_marker_code;
        got.length    = out_segment_length;
        got.pay_index = out_payload_index;
        got.exif      = out_exif_flag;
        got.evt       = event_t'(out_event_code);
        got.finished  = out_finished;
        sb.check_word(got);
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic send_word(input logic [7:0] b, input logic rs);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_restart   <= rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (sb.note_word(b, rs) != ROLE_IGNORED) live_words++;
  endtask

  task automatic send_stream();
    for (int i = 0; i < stream_q.size(); i++) send_word(stream_q[i], i == 0);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++)
      send_word(8'($urandom_range(0, 255)),
                (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 7) == 0));
  endtask

  // sender goes quiet until every queued result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic int pick_fills();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r <= 6) return 1;
    if (r <= 8) return $urandom_range(2, 6);
    return 6;
  endfunction

  function automatic logic [7:0] pick_marker();
    logic [7:0] m;
    do m = 8'($urandom_range(0, 254)); while (m == MK_EOI || m == MK_SOS);
    return m;
  endfunction

  function automatic void push_fills(int n);
    for (int i = 0; i < n; i++) stream_q.push_back(BYTE_FILL);
  endfunction

  function automatic void push_trailer(int n);
    for (int i = 0; i < n; i++) stream_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void push_segment(logic [7:0] mk, int plen, int exif_mode);
    logic [15:0] len;
    logic [7:0]  b;
    int          bad_pos;
    len     = 16'(plen + 2);
    bad_pos = (exif_mode == EXIF_FLIPPED) ? int'($urandom_range(0, 3)) : -1;
    stream_q.push_back(mk);
    stream_q.push_back(len[15:8]);
    stream_q.push_back(len[7:0]);
    for (int i = 0; i < plen; i++) begin
      if (exif_mode != EXIF_NONE && i < 4) begin
        b = EXIF_TAG[8*(3-i) +: 8];
        if (i == bad_pos) b = b ^ (8'h01 << $urandom_range(0, 7));
      end else b = 8'($urandom_range(0, 255));
      stream_q.push_back(b);
    end
  endfunction

  function automatic void build_good_file();
    int nseg;
    int r;
    stream_q.push_back(BYTE_FILL);
    stream_q.push_back(MK_SOI);
    nseg = $urandom_range(0, 4);
    for (int s = 0; s < nseg; s++) begin
      push_fills(pick_fills());
      case ($urandom_range(0, 5))
        0: push_segment(MK_APP1, $urandom_range(4, 9), EXIF_EXACT);
        1: push_segment(MK_APP1, $urandom_range(0, 3), EXIF_EXACT);
        2: push_segment(MK_APP1, $urandom_range(4, 8), EXIF_FLIPPED);
        default: begin
          // now and then a segment long enough to use the length high byte
          if ($urandom_range(0, 19) == 0)
            push_segment(pick_marker(), $urandom_range(254, 300), EXIF_NONE);
          else
            push_segment(pick_marker(), $urandom_range(0, 8), EXIF_NONE);
        end
      endcase
    end
    r = $urandom_range(0, 9);
    if (r <= 5) begin
      push_fills(pick_fills());
      push_segment(MK_SOS, $urandom_range(0, 6), EXIF_NONE);
      push_trailer($urandom_range(0, 3));
    end else if (r <= 7) begin
      push_fills(pick_fills());
      stream_q.push_back(MK_EOI);
      push_trailer($urandom_range(0, 2));
    end
  endfunction

  function automatic void build_broken_file();
    logic [7:0] b;
    case ($urandom_range(0, 4))
      0: stream_q.push_back(8'($urandom_range(0, 254)));
      1: begin
        stream_q.push_back(BYTE_FILL);
        do b = 8'($urandom_range(0, 255)); while (b == MK_SOI);
        stream_q.push_back(b);
      end
      2: begin
        stream_q.push_back(BYTE_FILL);
        stream_q.push_back(MK_SOI);
        if ($urandom_range(0, 1)) push_segment(pick_marker(), $urandom_range(0, 4), EXIF_NONE);
        push_fills(7);
      end
      3: begin
        stream_q.push_back(BYTE_FILL);
        stream_q.push_back(MK_SOI);
        push_fills(pick_fills());
        stream_q.push_back(pick_marker());
        stream_q.push_back(8'h00);
        stream_q.push_back(8'($urandom_range(0, 1)));
      end
      default: begin
        // huge length, with the payload cut short
        stream_q.push_back(BYTE_FILL);
        stream_q.push_back(MK_SOI);
        stream_q.push_back(pick_marker());
        stream_q.push_back(8'($urandom_range(1, 255)));
        stream_q.push_back(8'($urandom_range(0, 255)));
        push_trailer($urandom_range(0, 5));
      end
    endcase
    push_trailer($urandom_range(0, 3));
  endfunction

  initial begin
    int mode;
    int cur_mode;
    int kind;
    int keep;
    sb = new();
    cur_mode = -1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed files
    stream_q = {8'h00};
    send_stream();
    stream_q = {BYTE_FILL, MK_SOI, BYTE_FILL, BYTE_FILL, BYTE_FILL, BYTE_FILL,
                BYTE_FILL, BYTE_FILL, BYTE_FILL};
    send_stream();
    stream_q = {BYTE_FILL, MK_SOI, MK_APP1, 8'h00, 8'h03, EXIF_TAG[31:24], BYTE_FILL, MK_EOI};
    send_stream();
    stream_q = {BYTE_FILL, MK_SOI, MK_SOF0, 8'h00, 8'h01};
    send_stream();
    stream_q = {BYTE_FILL, MK_SOI, MK_SOS, 8'h00, 8'h02, 8'h7E};
    send_stream();

    while (live_words < LIVE_WORDS) begin
      mode = live_words * 4 / LIVE_WORDS;
      if (mode > 3) mode = 3;
      if (mode != cur_mode) begin
        wait_drained();
        cur_mode = mode;
        case (mode)
          0: begin
            in_idle_pct = 0;
            stall_pct   = 0;
            hold_left   = HOLD_CYCLES;
          end
          1: begin
            in_idle_pct = 76;
            stall_pct   = 0;
          end
          2: begin
            in_idle_pct = 0;
            stall_pct   = 76;
          end
          default: begin
            in_idle_pct = 13;
            stall_pct   = 13;
          end
        endcase
      end else if ($urandom_range(0, 15) == 0) begin
        wait_drained();
      end
      kind = $urandom_range(0, 9);
      stream_q.delete();
      if (kind <= 6) begin
        build_good_file();
      end else if (kind == 7) begin
        build_broken_file();
      end else if (kind == 9) begin
        // well-formed start, cut off anywhere
        build_good_file();
        keep = $urandom_range(1, stream_q.size());
        while (stream_q.size() > keep) void'(stream_q.pop_back());
      end
      if (kind == 8) send_noise();
      else send_stream();
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("jpeg_marker_segment_parser_unit test passed");
    end else begin
      $display("jpeg_marker_segment_parser_unit test failed");
    end
    $finish;
  end

endmodule
